@@ src/gnev_pkg.sv @@
package gnev_pkg;

  // field widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned COST_W     = 16;
  localparam int unsigned PLANE_W    = 2 * SIZE_W;
  localparam int unsigned TOTAL_W    = 3 * SIZE_W;
  localparam int unsigned MAP_CELLS  = 4096;
  localparam int unsigned MAP_AW     = $clog2(MAP_CELLS);
  localparam int unsigned DIV_STEPS  = IDX_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // stream packing
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COST_AXIS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COST_FACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COST_BODY = 3'd5;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST      = 5'd16;
  localparam logic [COST_W-1:0] COST_AXIS_RST = 16'd256;
  localparam logic [COST_W-1:0] COST_FACE_RST = 16'd362;
  localparam logic [COST_W-1:0] COST_BODY_RST = 16'd443;

  // default grid limits
  localparam int unsigned MAX_X_DEF = 16;
  localparam int unsigned MAX_Y_DEF = 16;
  localparam int unsigned MAX_Z_DEF = 16;

  // item kinds
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic plane;
    logic div_load_z;
    logic div_step;
    logic div_load_y;
    logic walk_init;
    logic walk;
    logic flush;
  } gnev_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic range_ok;
    logic div_last;
    logic walk_done;
    logic out_free;
  } gnev_sts_t;

endpackage

@@ src/gnev_ram.sv @@
module gnev_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gnev_ctrl.sv @@
module gnev_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  output logic               in_ready_o,
  output gnev_pkg::gnev_cmd_t cmd_o,
  input  gnev_pkg::gnev_sts_t sts_i
);
  import gnev_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PLANE = 9'b000000100,
    S_RANGE = 9'b000001000,
    S_DIVZ  = 9'b000010000,
    S_LOADY = 9'b000100000,
    S_DIVY  = 9'b001000000,
    S_LOADW = 9'b010000000,
    S_WALK  = 9'b100000000
  } state_e;

  typedef enum logic {
    F_OFF = 1'b0,
    F_ON  = 1'b1
  } flush_e;

  state_e state_q, state_d;
  flush_e flush_q, flush_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    flush_d    = flush_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    if (flush_q == F_ON) begin
      // final result of a query waits for a free output slot
      cmd_o.flush = 1'b1;
      if (sts_i.out_free) begin
        flush_d = F_OFF;
        state_d = S_IDLE;
      end
    end else begin
      case (state_q)
        S_CLEAR: begin
          cmd_o.clear = 1'b1;
          if (sts_i.clear_last) begin
            state_d = S_IDLE;
          end
        end
        S_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            if (in_opcode_i == OP_QUERY) begin
              state_d = S_PLANE;
            end
          end
        end
        S_PLANE: begin
          cmd_o.plane = 1'b1;
          state_d     = S_RANGE;
        end
        S_RANGE: begin
          if (sts_i.range_ok) begin
            cmd_o.div_load_z = 1'b1;
            state_d          = S_DIVZ;
          end else begin
            flush_d = F_ON;
          end
        end
        S_DIVZ: begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_d = S_LOADY;
          end
        end
        S_LOADY: begin
          cmd_o.div_load_y = 1'b1;
          state_d          = S_DIVY;
        end
        S_DIVY: begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_d = S_LOADW;
          end
        end
        S_LOADW: begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WALK;
        end
        S_WALK: begin
          cmd_o.walk = 1'b1;
          if (sts_i.walk_done) begin
            flush_d = F_ON;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      flush_q <= F_OFF;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

endmodule

@@ src/gnev_dp.sv @@
module gnev_dp #(
  parameter int unsigned MAX_X = gnev_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = gnev_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = gnev_pkg::MAX_Z_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gnev_pkg::gnev_cmd_t             cmd_i,
  output gnev_pkg::gnev_sts_t             sts_o,
  input  logic                            in_opcode_i,
  input  logic [gnev_pkg::IDX_W-1:0]      in_cell_index_i,
  input  logic                            in_blocked_i,
  input  logic                            cfg_we_i,
  input  logic [gnev_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gnev_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gnev_pkg::IDX_W-1:0]      out_index_o,
  output logic [gnev_pkg::COST_W-1:0]     out_cost_o,
  output logic                            out_found_o,
  output logic                            out_last_o
);
  import gnev_pkg::*;

  localparam int unsigned SIZE_TOP = (1 << SIZE_W) - 1;
  localparam int unsigned LIM_X    = (MAX_X < SIZE_TOP) ? MAX_X : SIZE_TOP;
  localparam int unsigned LIM_Y    = (MAX_Y < SIZE_TOP) ? MAX_Y : SIZE_TOP;
  localparam int unsigned LIM_Z    = (MAX_Z < SIZE_TOP) ? MAX_Z : SIZE_TOP;
  localparam int unsigned LIN_W    = TOTAL_W + 2;

  // offset digit codes
  localparam logic [1:0] D_NEG  = 2'd0;
  localparam logic [1:0] D_ZERO = 2'd1;
  localparam logic [1:0] D_POS  = 2'd2;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic logic signed [LIN_W-1:0] offs(input logic [1:0] d,
                                                   input logic signed [LIN_W-1:0] s);
    logic signed [LIN_W-1:0] r;
    case (d)
      D_NEG:   r = -s;
      D_POS:   r = s;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic axis_ok(input logic [SIZE_W-1:0] c, input logic [SIZE_W-1:0] s,
                                   input logic [1:0] d);
    logic lo_ok, hi_ok;
    lo_ok = !((d == D_NEG) && (c == '0));
    hi_ok = !((d == D_POS) && (({1'b0, c} + (SIZE_W + 1)'(1)) == {1'b0, s}));
    return lo_ok && hi_ok;
  endfunction

  // configuration registers
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [COST_W-1:0] cost_axis_q, cost_face_q, cost_body_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q    <= SIZE_RST;
      size_y_q    <= SIZE_RST;
      size_z_q    <= SIZE_RST;
      cost_axis_q <= COST_AXIS_RST;
      cost_face_q <= COST_FACE_RST;
      cost_body_q <= COST_BODY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SIZE_X:    size_x_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:    size_y_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:    size_z_q    <= cfg_data_i[SIZE_W-1:0];
        REG_COST_AXIS: cost_axis_q <= cfg_data_i[COST_W-1:0];
        REG_COST_FACE: cost_face_q <= cfg_data_i[COST_W-1:0];
        REG_COST_BODY: cost_body_q <= cfg_data_i[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // extents in use
  logic [SIZE_W-1:0] sx, sy, sz;
  assign sx = clamp_size(size_x_q, SIZE_W'(LIM_X));
  assign sy = clamp_size(size_y_q, SIZE_W'(LIM_Y));
  assign sz = clamp_size(size_z_q, SIZE_W'(LIM_Z));

  // query index and grid area
  logic [IDX_W-1:0]   idx_q;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [TOTAL_W-1:0] total;

  assign plane_d = {{SIZE_W{1'b0}}, sx} * {{SIZE_W{1'b0}}, sy};
  assign total   = {{SIZE_W{1'b0}}, plane_q} * {{PLANE_W{1'b0}}, sz};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= in_cell_index_i;
    end
    if (cmd_i.plane) begin
      plane_q <= plane_d;
    end
  end

  assign sts_o.range_ok = {{(TOTAL_W - IDX_W){1'b0}}, idx_q} < total;

  // bit-serial restoring divider, shared by the z and y decode
  logic [IDX_W-1:0]     dvd_q, quo_q;
  logic [PLANE_W-1:0]   rem_q, dvs_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [PLANE_W:0]     div_trial;
  logic                 div_take;

  assign div_trial = {rem_q, dvd_q[IDX_W-1]};
  assign div_take  = div_trial >= {1'b0, dvs_q};
  assign sts_o.div_last = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

  // decoded coordinates
  logic [SIZE_W-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_z) begin
      dvd_q     <= idx_q;
      dvs_q     <= plane_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_load_y) begin
      cz_q      <= quo_q[SIZE_W-1:0];
      dvd_q     <= {{(IDX_W - PLANE_W){1'b0}}, rem_q};
      dvs_q     <= {{SIZE_W{1'b0}}, sx};
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q     <= {dvd_q[IDX_W-2:0], 1'b0};
      quo_q     <= {quo_q[IDX_W-2:0], div_take};
      rem_q     <= div_take ? PLANE_W'(div_trial - {1'b0, dvs_q}) : div_trial[PLANE_W-1:0];
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.walk_init) begin
      cy_q <= quo_q[SIZE_W-1:0];
      cx_q <= rem_q[SIZE_W-1:0];
    end
  end

  // offset walk, stage a: position check and map read
  logic [1:0]              dx_q, dy_q, dz_q;
  logic                    a_done_q;
  logic signed [LIN_W-1:0] a_lin;
  logic                    a_ok;
  logic                    a_last;

  assign a_lin = $signed({{(LIN_W - IDX_W){1'b0}}, idx_q})
               + offs(dx_q, LIN_W'(1))
               + offs(dy_q, $signed({{(LIN_W - SIZE_W){1'b0}}, sx}))
               + offs(dz_q, $signed({{(LIN_W - PLANE_W){1'b0}}, plane_q}));
  assign a_ok  = !((dx_q == D_ZERO) && (dy_q == D_ZERO) && (dz_q == D_ZERO))
               && axis_ok(cx_q, sx, dx_q) && axis_ok(cy_q, sy, dy_q)
               && axis_ok(cz_q, sz, dz_q)
               && (a_lin[LIN_W-1:IDX_W] == '0);
  assign a_last = (dx_q == D_POS) && (dy_q == D_POS) && (dz_q == D_POS);

  // stage b: map bit arrives, candidate result formed
  logic              b_valid_q, b_ok_q;
  logic [IDX_W-1:0]  b_lin_q;
  logic [1:0]        b_moved_q;
  logic              map_bit;
  logic              b_free;
  logic [COST_W-1:0] b_cost;

  assign b_free = b_valid_q && b_ok_q && !map_bit;

  always_comb begin
    case (b_moved_q)
      2'd2:    b_cost = cost_face_q;
      2'd3:    b_cost = cost_body_q;
      default: b_cost = cost_axis_q;
    endcase
  end

  // one result held back until it is known whether it is the last
  logic              hold_valid_q;
  logic [IDX_W-1:0]  hold_idx_q;
  logic [COST_W-1:0] hold_cost_q;

  // output register
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [COST_W-1:0] out_cost_q;
  logic              out_found_q, out_last_q;
  logic              out_free;

  assign out_free       = !out_valid_q || out_ready_i;
  assign sts_o.out_free = out_free;

  logic b_stall, adv, push_mid, push_end;

  assign b_stall  = b_free && hold_valid_q && !out_free;
  assign adv      = cmd_i.walk && !b_stall;
  assign push_mid = adv && b_free && hold_valid_q;
  assign push_end = cmd_i.flush && out_free;

  assign sts_o.walk_done = a_done_q && !b_valid_q;

  // walk counters and stage b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q      <= D_NEG;
      dy_q      <= D_NEG;
      dz_q      <= D_NEG;
      a_done_q  <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      dx_q      <= D_NEG;
      dy_q      <= D_NEG;
      dz_q      <= D_NEG;
      a_done_q  <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= !a_done_q;
      if (!a_done_q) begin
        if (a_last) begin
          a_done_q <= 1'b1;
        end else if (dz_q != D_POS) begin
          dz_q <= dz_q + 2'd1;
        end else begin
          dz_q <= D_NEG;
          if (dy_q != D_POS) begin
            dy_q <= dy_q + 2'd1;
          end else begin
            dy_q <= D_NEG;
            dx_q <= dx_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !a_done_q) begin
      b_ok_q    <= a_ok;
      b_lin_q   <= a_lin[IDX_W-1:0];
      b_moved_q <= 2'((dx_q != D_ZERO)) + 2'((dy_q != D_ZERO)) + 2'((dz_q != D_ZERO));
    end
  end

  // held result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      hold_valid_q <= 1'b0;
    end else if (adv && b_free) begin
      hold_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_free) begin
      hold_idx_q  <= b_lin_q;
      hold_cost_q <= b_cost;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid) begin
      out_idx_q   <= hold_idx_q;
      out_cost_q  <= hold_cost_q;
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else if (push_end) begin
      out_idx_q   <= hold_valid_q ? hold_idx_q : '0;
      out_cost_q  <= hold_valid_q ? hold_cost_q : '0;
      out_found_q <= hold_valid_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_idx_q;
  assign out_cost_o  = out_cost_q;
  assign out_found_o = out_found_q;
  assign out_last_o  = out_last_q;

  // clearing pass counter
  logic [MAP_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
    end
  end

  assign sts_o.clear_last = clr_cnt_q == MAP_AW'(MAP_CELLS - 1);

  // obstacle map
  logic              map_we, map_wbit, map_re;
  logic [MAP_AW-1:0] map_waddr;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_cnt_q;
    map_wbit  = 1'b0;
    if (cmd_i.clear) begin
      map_we = 1'b1;
    end else if (cmd_i.load && (in_opcode_i == OP_WRITE)) begin
      map_we    = 1'b1;
      map_waddr = in_cell_index_i[MAP_AW-1:0];
      map_wbit  = in_blocked_i;
    end
  end

  assign map_re = adv && !a_done_q && a_ok;

  gnev_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wbit),
    .re_i    (map_re),
    .raddr_i (a_lin[MAP_AW-1:0]),
    .rdata_o (map_bit)
  );

endmodule

@@ src/grid_neighbor_enumerator_3d_unit.sv @@
// 3D grid neighbour enumerator. Holds a one-bit obstacle map of 4096 cells,
// addressed by linear index x + size_x*y + size_x*size_y*z. After reset the
// block runs a clearing pass over the map, one cell per cycle, and accepts
// no item until it ends; configuration writes are taken at any time. A write
// item (tuser 0) gives no result. A query item (tuser 1) is decoded by a
// bit-serial divider (12 steps for z, 12 for y), then the 26 neighbour
// offsets are walked, one map read per cycle while tready low does not hold
// the output, giving one result per free in-grid neighbour with its Q8.8
// step cost and tlast on the final one, or a single result with found clear
// when none is free or the index lies outside the grid. Queries are served
// one at a time; a finished result waits in the output register while the
// next item is accepted.
module grid_neighbor_enumerator_3d_unit #(
  parameter int unsigned MAX_X = gnev_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = gnev_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z = gnev_pkg::MAX_Z_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gnev_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // cell_index, blocked_value, zeros
  input  logic [0:0]                      s_axis_tuser,  // opcode
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gnev_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // neighbor_index, step_cost, zeros
  output logic [0:0]                      m_axis_tuser,  // found
  output logic                            m_axis_tlast,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gnev_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gnev_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gnev_pkg::*;

  gnev_cmd_t         cmd;
  gnev_sts_t         sts;
  logic [IDX_W-1:0]  nb_index;
  logic [COST_W-1:0] nb_cost;
  logic              nb_found;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  gnev_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gnev_dp #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_opcode_i     (s_axis_tuser[0]),
    .in_cell_index_i (s_axis_tdata[IDX_W-1:0]),
    .in_blocked_i    (s_axis_tdata[IDX_W]),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_index_o     (nb_index),
    .out_cost_o      (nb_cost),
    .out_found_o     (nb_found),
    .out_last_o      (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {{(M_TDATA_W - IDX_W - COST_W){1'b0}}, nb_cost, nb_index};
  assign m_axis_tuser = nb_found;

endmodule
